### rtl/pcc_pkg.sv
`default_nettype none

package pcc_pkg;

  localparam int unsigned ArityW = 3;
  localparam int unsigned TableW = 32;
  localparam int unsigned MaxArityDefault = 5;

  typedef struct packed {
    logic linear;
    logic monotone;
    logic self_dual;
    logic one;
    logic zero;
  } flags_t;

endpackage

`default_nettype wire

### rtl/pcc_intf.sv
`default_nettype none

interface pcc_in_if;
  import pcc_pkg::*;

  logic              valid;
  logic              ready;
  logic [ArityW-1:0] arity;
  logic [TableW-1:0] truth_table;
  logic              last_in_set;

  modport source (output valid, output arity, output truth_table, output last_in_set,
                  input ready);
  modport sink (input valid, input arity, input truth_table, input last_in_set,
                output ready);
endinterface

interface pcc_out_if;
  logic valid;
  logic ready;
  logic escapes_zero;
  logic escapes_one;
  logic escapes_self_dual;
  logic escapes_monotone;
  logic escapes_linear;
  logic complete;

  modport source (output valid, output escapes_zero, output escapes_one,
                  output escapes_self_dual, output escapes_monotone,
                  output escapes_linear, output complete, input ready);
  modport sink (input valid, input escapes_zero, input escapes_one,
                input escapes_self_dual, input escapes_monotone,
                input escapes_linear, input complete, output ready);
endinterface

`default_nettype wire

### rtl/pcc_classify.sv
`default_nettype none

module pcc_classify import pcc_pkg::*; #(
  parameter int unsigned MaxArity = MaxArityDefault
) (
  input  logic [ArityW-1:0] arity_i,
  input  logic [TableW-1:0] truth_table_i,
  output flags_t            flags_o
);

  localparam int unsigned TableBits = 1 << MaxArity;
  localparam int unsigned SelW = (MaxArity > 1) ? $clog2(MaxArity + 1) : 1;

  logic [ArityW-1:0]    n;
  logic [TableBits-1:0] tbl_raw;
  logic [TableBits-1:0] tbl;
  logic [MaxArity:0]    one_esc;
  logic [MaxArity:0]    sd_esc;
  logic                 mono;
  logic [TableBits-1:0] anf [MaxArity+1];
  logic [TableBits-1:0] high_deg;

  assign n = (arity_i > ArityW'(MaxArity)) ? ArityW'(MaxArity) : arity_i;

  for (genvar i = 0; i < TableBits; i++) begin : g_raw
    if (i < TableW) begin : g_in
      assign tbl_raw[i] = truth_table_i[i];
    end else begin : g_pad
      assign tbl_raw[i] = 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < TableBits; i++) begin
      tbl[i] = tbl_raw[i] & ((i >> n) == 0);
    end
  end

  // Each arity has fixed corner and complement positions; the live one is selected.
  for (genvar m = 0; m <= MaxArity; m++) begin : g_arity
    localparam int unsigned Full = (1 << m) - 1;
    logic [Full:0] hit;
    for (genvar i = 0; i <= Full; i++) begin : g_pair
      assign hit[i] = tbl[i] ~^ tbl[Full ^ i];
    end
    assign sd_esc[m]  = |hit;
    assign one_esc[m] = ~tbl[Full];
  end

  always_comb begin
    mono = 1'b0;
    for (int k = 0; k < MaxArity; k++) begin
      for (int i = 0; i < TableBits; i++) begin
        if ((((i >> k) & 1) == 0) && (k < n)) begin
          mono = mono | (tbl[i] & ~tbl[i | (1 << k)]);
        end
      end
    end
  end

  // Moebius transform, one stage per variable; stages beyond the arity pass through.
  assign anf[0] = tbl;
  for (genvar k = 0; k < MaxArity; k++) begin : g_stage
    for (genvar i = 0; i < TableBits; i++) begin : g_bit
      if (((i >> k) & 1) == 1) begin : g_xor
        assign anf[k+1][i] = anf[k][i] ^ (anf[k][i ^ (1 << k)] & (n > ArityW'(k)));
      end else begin : g_keep
        assign anf[k+1][i] = anf[k][i];
      end
    end
  end

  for (genvar i = 0; i < TableBits; i++) begin : g_deg
    if ((i & (i - 1)) != 0) begin : g_multi
      assign high_deg[i] = anf[MaxArity][i];
    end else begin : g_single
      assign high_deg[i] = 1'b0;
    end
  end

  assign flags_o.zero      = tbl[0];
  assign flags_o.one       = one_esc[n[SelW-1:0]];
  assign flags_o.self_dual = sd_esc[n[SelW-1:0]];
  assign flags_o.monotone  = mono;
  assign flags_o.linear    = |high_deg;

endmodule

`default_nettype wire

### rtl/post_completeness_checker_core.sv
// Post completeness checker.
// Boolean functions arrive one word at a time on in_i: an arity, a truth table
// whose bit i is f(i), and a flag that marks the last function of a set. For
// every word accepted, one word leaves on out_o with the five sticky escape
// flags (zero-preserving, one-preserving, self-dual, monotone, linear) as they
// stand after that function, and complete, which is high when all five are set.
// The flags clear after the word marked last has been taken into account.
// Each word passes through one input register, the classification logic, then
// the result register that also holds the sticky flags; out_o.valid comes from
// the result register.
// A new word is accepted every cycle while results flow.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more word; after that in_i.ready falls until the
// result is taken. Arities above MaxArity are treated as MaxArity.
// Reset clears both valid bits and the sticky flags.
`default_nettype none

module post_completeness_checker_core import pcc_pkg::*; #(
  parameter int unsigned MaxArity = MaxArityDefault
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  pcc_in_if.sink          in_i,
  pcc_out_if.source       out_o
);

  logic              s1_valid_q, s1_valid_d;
  logic [ArityW-1:0] s1_arity_q;
  logic [TableW-1:0] s1_table_q;
  logic              s1_last_q;
  flags_t            sticky_q, sticky_d;
  logic              out_valid_q, out_valid_d;
  flags_t            out_flags_q;
  flags_t            cls;
  flags_t            merged;
  logic              out_free;
  logic              advance;
  logic              in_take;

  pcc_classify #(
    .MaxArity (MaxArity)
  ) u_classify (
    .arity_i       (s1_arity_q),
    .truth_table_i (s1_table_q),
    .flags_o       (cls)
  );

  assign merged   = sticky_q | cls;
  assign out_free = ~out_valid_q | out_o.ready;
  assign advance  = s1_valid_q & out_free;
  assign in_take  = in_i.valid & in_i.ready;

  assign in_i.ready = ~s1_valid_q | out_free;

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    sticky_d    = sticky_q;
    if (advance) begin
      s1_valid_d = 1'b0;
      sticky_d   = s1_last_q ? '0 : merged;
    end
    if (in_take) begin
      s1_valid_d = 1'b1;
    end
    if (out_free) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      sticky_q    <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      sticky_q    <= sticky_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_arity_q <= in_i.arity;
      s1_table_q <= in_i.truth_table;
      s1_last_q  <= in_i.last_in_set;
    end
    if (advance) begin
      out_flags_q <= merged;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.escapes_zero      = out_flags_q.zero;
  assign out_o.escapes_one       = out_flags_q.one;
  assign out_o.escapes_self_dual = out_flags_q.self_dual;
  assign out_o.escapes_monotone  = out_flags_q.monotone;
  assign out_o.escapes_linear    = out_flags_q.linear;
  assign out_o.complete          = &out_flags_q;

endmodule

`default_nettype wire
